/* hw/rtl/tlspq_pkg.sv */
// ----------------------------------------------------------------------------
// tlspq_pkg
// Shared types and codes of the three-level strict-priority queue.
// ----------------------------------------------------------------------------
package tlspq_pkg;

    localparam int NUM_LEVELS = 3;
    localparam int LVL_W      = 2;

    localparam int CMD_W   = 1;
    localparam int PRI_W   = 3;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;
    localparam int SERVE_W = 2;

    // s_tdata: priority_req, push_value; m_tdata: pop_value, served_level
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;
    localparam int S_TUSER_W = 1;
    localparam int M_TUSER_W = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH = 1'b0;
    localparam logic [CMD_W-1:0] CMD_POP  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADPRI = 2'd3;

    // datapath to controller
    typedef struct packed {
        logic is_pop;
        logic pri_valid;
        logic lvl_full;
        logic all_empty;
        logic out_free;
    } dp_status_t;

    // controller to datapath
    typedef struct packed {
        logic              capture;
        logic              commit_push;
        logic              commit_pop;
        logic              load_imm;
        logic              load_mem;
        logic [STAT_W-1:0] imm_status;
    } dp_cmd_t;

endpackage

/* hw/rtl/three_level_strict_priority_queue_core.sv */
// ----------------------------------------------------------------------------
// three_level_strict_priority_queue_core
// Three ring-buffer FIFOs, levels 1 to 3, served in strict priority order.
// ----------------------------------------------------------------------------
// Sequence: the word is captured on accept; a push or a refused word has its
// result loaded in EXEC, while a pop that finds a word reads the store into a
// register in EXEC and is loaded in READ. Both states wait while the result
// register is held. The sequencer handles one word at a time.
// Reset (aresetn low, synchronous): all levels empty, pointers at slot 0,
// no result pending. Store contents are not cleared.
// ----------------------------------------------------------------------------
module three_level_strict_priority_queue_core #(
    parameter int LEVEL_DEPTH = 16,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [2:0] priority_req, [34:3] push_value, [39:35] zero
    input  logic [tlspq_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] cmd
    input  logic [tlspq_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [31:0] pop_value, [33:32] served_level, [39:34] zero
    output logic [tlspq_pkg::M_TDATA_W-1:0] m_tdata,
    // [1:0] status
    output logic [tlspq_pkg::M_TUSER_W-1:0] m_tuser
);
    import tlspq_pkg::*;

    dp_status_t dp_status;
    dp_cmd_t    dp_cmd;

    tlspq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    tlspq_dp #(
        .LEVEL_DEPTH (LEVEL_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (dp_cmd),
        .status   (dp_status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

/* hw/rtl/tlspq_ctrl.sv */
// ----------------------------------------------------------------------------
// tlspq_ctrl
// Sequencer: take a word, decide push or pop, commit, load the result.
// ----------------------------------------------------------------------------
module tlspq_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  tlspq_pkg::dp_status_t status,
    output tlspq_pkg::dp_cmd_t    cmd
);
    import tlspq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        s_tready       = 1'b0;
        cmd            = '0;
        cmd.imm_status = ST_OK;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                // hold until the result register can take a word
                if (status.out_free) begin
                    if (!status.is_pop) begin
                        cmd.load_imm = 1'b1;
                        state_next   = S_IDLE;
                        if (!status.pri_valid) begin
                            cmd.imm_status = ST_BADPRI;
                        end else if (status.lvl_full) begin
                            cmd.imm_status = ST_FULL;
                        end else begin
                            cmd.imm_status  = ST_OK;
                            cmd.commit_push = 1'b1;
                        end
                    end else if (status.all_empty) begin
                        cmd.load_imm   = 1'b1;
                        cmd.imm_status = ST_EMPTY;
                        state_next     = S_IDLE;
                    end else begin
                        cmd.commit_pop = 1'b1;
                        state_next     = S_READ;
                    end
                end
            end
            S_READ: begin
                if (status.out_free) begin
                    cmd.load_mem = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/tlspq_dp.sv */
// ----------------------------------------------------------------------------
// tlspq_dp
// Ring-buffer store, per-level pointers and counts, result register.
// ----------------------------------------------------------------------------
module tlspq_dp #(
    parameter int LEVEL_DEPTH = 16,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [tlspq_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [tlspq_pkg::S_TUSER_W-1:0]   s_tuser,
    input  tlspq_pkg::dp_cmd_t                cmd,
    output tlspq_pkg::dp_status_t             status,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tlspq_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [tlspq_pkg::M_TUSER_W-1:0]   m_tuser
);
    import tlspq_pkg::*;

    localparam int IW    = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
    localparam int CW    = $clog2(LEVEL_DEPTH + 1);
    localparam int WORDS = NUM_LEVELS * LEVEL_DEPTH;
    localparam int AW    = $clog2(WORDS);
    localparam logic [AW-1:0] DEPTH_A  = AW'(LEVEL_DEPTH);
    localparam logic [CW-1:0] DEPTH_C  = CW'(LEVEL_DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(LEVEL_DEPTH - 1);

    logic [DATA_WIDTH-1:0] mem [WORDS];

    logic [CMD_W-1:0]   cmd_reg;
    logic [PRI_W-1:0]   pri_reg;
    logic [VALUE_W-1:0] val_reg;

    logic [IW-1:0] head_reg [NUM_LEVELS];
    logic [IW-1:0] tail_reg [NUM_LEVELS];
    logic [CW-1:0] cnt_reg  [NUM_LEVELS];

    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic [LVL_W-1:0]      pop_lv_reg;

    logic                m_valid_reg;
    logic [VALUE_W-1:0]  pop_value_reg;
    logic [STAT_W-1:0]   status_reg;
    logic [SERVE_W-1:0]  served_reg;

    logic [2**LVL_W-1:0] full_vec;
    logic [2**LVL_W-1:0] busy_vec;
    logic [LVL_W-1:0]    push_lv;
    logic [LVL_W-1:0]    pop_lv;
    logic [IW-1:0]       tail_sel;
    logic [IW-1:0]       head_sel;
    logic [AW-1:0]       wr_addr;
    logic [AW-1:0]       rd_addr;
    logic                pri_valid;
    logic                out_free;

    function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    assign pri_valid = (pri_reg != '0) && (pri_reg <= PRI_W'(NUM_LEVELS));
    assign push_lv   = LVL_W'(pri_reg - 1'b1);
    assign out_free  = !m_valid_reg || m_tready;

    always_comb begin
        full_vec = '0;
        busy_vec = '0;
        tail_sel = '0;
        head_sel = '0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            full_vec[i] = (cnt_reg[i] == DEPTH_C);
            busy_vec[i] = (cnt_reg[i] != '0);
        end
        // strict priority: lowest-numbered level with words wins
        if (busy_vec[0]) begin
            pop_lv = LVL_W'(0);
        end else if (busy_vec[1]) begin
            pop_lv = LVL_W'(1);
        end else begin
            pop_lv = LVL_W'(2);
        end
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (push_lv == LVL_W'(i)) begin
                tail_sel = tail_reg[i];
            end
            if (pop_lv == LVL_W'(i)) begin
                head_sel = head_reg[i];
            end
        end
    end

    assign wr_addr = AW'(push_lv) * DEPTH_A + AW'(tail_sel);
    assign rd_addr = AW'(pop_lv) * DEPTH_A + AW'(head_sel);

    always_comb begin
        status.is_pop    = (cmd_reg == CMD_POP);
        status.pri_valid = pri_valid;
        status.lvl_full  = pri_valid && full_vec[push_lv];
        status.all_empty = (busy_vec == '0);
        status.out_free  = out_free;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
            m_valid_reg <= 1'b0;
        end else begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
                if (cmd.commit_push && push_lv == LVL_W'(i)) begin
                    tail_reg[i] <= next_slot(tail_reg[i]);
                    cnt_reg[i]  <= cnt_reg[i] + 1'b1;
                end
                if (cmd.commit_pop && pop_lv == LVL_W'(i)) begin
                    head_reg[i] <= next_slot(head_reg[i]);
                    cnt_reg[i]  <= cnt_reg[i] - 1'b1;
                end
            end
            if (cmd.load_imm || cmd.load_mem) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cmd_reg <= s_tuser[CMD_W-1:0];
            pri_reg <= s_tdata[PRI_W-1:0];
            val_reg <= s_tdata[PRI_W +: VALUE_W];
        end
        if (cmd.commit_push) begin
            mem[wr_addr] <= DATA_WIDTH'($signed(val_reg));
        end
        if (cmd.commit_pop) begin
            rd_data_reg <= mem[rd_addr];
            pop_lv_reg  <= pop_lv;
        end
        if (cmd.load_imm) begin
            pop_value_reg <= '0;
            status_reg    <= cmd.imm_status;
            served_reg    <= (cmd.imm_status == ST_OK) ? SERVE_W'(pri_reg) : '0;
        end else if (cmd.load_mem) begin
            pop_value_reg <= VALUE_W'($signed(rd_data_reg));
            status_reg    <= ST_OK;
            served_reg    <= SERVE_W'(pop_lv_reg) + 1'b1;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - VALUE_W - SERVE_W){1'b0}}, served_reg, pop_value_reg};
    assign m_tuser  = status_reg;

endmodule
